[src/hid_boot_device_poller_top_macros.svh]
// ---------------------------------------------------------------------------
// hid_boot_device_poller_top_macros
// Assertion macros for the boot device poller, empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef HID_BOOT_DEVICE_POLLER_TOP_MACROS_SVH
`define HID_BOOT_DEVICE_POLLER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define HBDP_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

`define HBDP_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`else

`define HBDP_ASSERT_IMP(lbl, a, b)

`define HBDP_ASSERT_NXT(lbl, a, b)

`endif

`endif

[src/hbdp_pkg.sv]
// ---------------------------------------------------------------------------
// hbdp_pkg
// Types and constants of the boot device poller.
// ---------------------------------------------------------------------------
package hbdp_pkg;

  localparam int unsigned PosW = 16;

  localparam logic [PosW-1:0] PosMax       = '1;
  localparam logic [7:0]      PollReset    = 8'd10;
  localparam logic [7:0]      IdleReset    = 8'd255;
  localparam logic [7:0]      DescIface    = 8'h04;
  localparam logic [7:0]      SubclassBoot = 8'h01;
  localparam logic [7:0]      ProtoKbd     = 8'h01;
  localparam logic [7:0]      ProtoMouse   = 8'h02;
  localparam logic [2:0]      SlotMouse    = 3'd5;
  localparam logic [2:0]      SlotOther    = 3'd6;
  localparam logic [3:0]      LenMouse     = 4'd4;
  localparam logic [3:0]      LenKbd       = 4'd8;
  localparam logic [3:0]      OffSubclass  = 4'd6;
  localparam logic [3:0]      OffProtocol  = 4'd7;

  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_STEP = 2'd1,
    ACT_DONE = 2'd2,
    ACT_TICK = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    RESP_OK    = 2'd0,
    RESP_STALL = 2'd1,
    RESP_ERROR = 2'd2,
    RESP_OTHER = 2'd3
  } resp_t;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_KBD    = 3'd1,
    KIND_MOUSE  = 3'd2,
    KIND_UNREC  = 3'd3,
    KIND_ISSUE  = 3'd4,
    KIND_RPT_OK = 3'd5,
    KIND_RPT_ER = 3'd6,
    KIND_STALL  = 3'd7
  } kind_t;

  typedef enum logic [5:0] {
    PH_GET  = 6'b000001,
    PH_MSE1 = 6'b000010,
    PH_MSE2 = 6'b000100,
    PH_KBD1 = 6'b001000,
    PH_KBD2 = 6'b010000,
    PH_IDLE = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    REG_SIM  = 2'd0,
    REG_POLL = 2'd1,
    REG_IDLE = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_t;

endpackage

[src/hid_boot_device_poller_top.sv]
// ---------------------------------------------------------------------------
// hid_boot_device_poller_top
// Host-side sequencer for a boot keyboard or mouse: walks the configuration
// descriptor, detects the boot interface and drives the IN polling loop.
// Results are registered: out_valid rises in the cycle after a request is accepted.
// Throughput: one request per cycle while the result is taken; state updates in a single register pass.
// Reset: synchronous; state and config registers return to their defaults, output empties.
// ---------------------------------------------------------------------------
`include "hid_boot_device_poller_top_macros.svh"

module hid_boot_device_poller_top
  import hbdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  input  logic [1:0] response,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] protocol,
  output logic [2:0] endpoint_slot,
  output logic [3:0] request_length,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic            sim_mode;
  logic [7:0]      poll_interval;
  logic [7:0]      idle_interval;

  phase_t          phase, phase_next;
  logic            slot_assigned, slot_assigned_next;
  logic            slot_busy, slot_busy_next;
  logic [2:0]      slot_number, slot_number_next;
  logic [1:0]      last_response, last_response_next;
  logic [7:0]      wait_count, wait_count_next;
  logic [PosW-1:0] byte_position, byte_position_next;
  logic [PosW-1:0] next_header_position, next_header_position_next;
  logic [PosW-1:0] total_length, total_length_next;
  logic            iface_found, iface_found_next;
  logic [PosW-1:0] iface_start, iface_start_next;
  logic [7:0]      iface_subclass, iface_subclass_next;
  logic [7:0]      iface_protocol, iface_protocol_next;
  logic [7:0]      hdr_len, hdr_len_next;
  logic            walk_stopped, walk_stopped_next;

  logic            in_fire;
  logic [2:0]      kind_next;
  logic [7:0]      proto_next;
  logic [3:0]      len_next;

  logic            take_ok;
  logic [PosW-1:0] tl_new;
  logic            walk_on;
  logic            at_hdr;
  logic            at_type;
  logic [PosW:0]   hdr_sum;
  logic [PosW-1:0] hdr_sat;
  logic            at_sub;
  logic            at_proto;
  logic [7:0]      detected;
  logic            is_mouse;
  logic            wait_zero;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign take_ok = byte_position != PosMax;
  assign tl_new  = (byte_position == PosW'(2)) ? {total_length[15:8], data_byte} :
                   (byte_position == PosW'(3)) ? {data_byte, total_length[7:0]} :
                   total_length;
  assign walk_on = !walk_stopped && !iface_found && (next_header_position < tl_new);
  assign at_hdr  = byte_position == next_header_position;
  assign at_type = {1'b0, byte_position} == ({1'b0, next_header_position} + (PosW+1)'(1));
  assign hdr_sum = {1'b0, next_header_position} + {{(PosW-7){1'b0}}, hdr_len};
  assign hdr_sat = hdr_sum[PosW] ? PosMax : hdr_sum[PosW-1:0];
  assign at_sub  = iface_found &&
                   ({1'b0, byte_position} == ({1'b0, iface_start} + (PosW+1)'(OffSubclass)));
  assign at_proto = iface_found &&
                    ({1'b0, byte_position} == ({1'b0, iface_start} + (PosW+1)'(OffProtocol)));

  assign detected = (!iface_found || (iface_start >= total_length) ||
                     (iface_subclass != SubclassBoot)) ? 8'd0 : iface_protocol;
  assign is_mouse = (phase == PH_MSE1) || (phase == PH_MSE2);
  assign wait_zero = sim_mode || (wait_count == 8'd0);

  always_comb begin
    phase_next                = phase;
    slot_assigned_next        = slot_assigned;
    slot_busy_next            = slot_busy;
    slot_number_next          = slot_number;
    last_response_next        = last_response;
    wait_count_next           = wait_count;
    byte_position_next        = byte_position;
    next_header_position_next = next_header_position;
    total_length_next         = total_length;
    iface_found_next          = iface_found;
    iface_start_next          = iface_start;
    iface_subclass_next       = iface_subclass;
    iface_protocol_next       = iface_protocol;
    hdr_len_next              = hdr_len;
    walk_stopped_next         = walk_stopped;
    kind_next                 = KIND_NONE;
    proto_next                = 8'd0;
    len_next                  = 4'd0;

    unique case (action_t'(action))
      ACT_BYTE: begin
        if (take_ok) begin
          total_length_next = tl_new;
          if (walk_on) begin
            if (at_hdr) begin
              hdr_len_next = data_byte;
            end else if (at_type) begin
              if (data_byte == DescIface) begin
                iface_found_next = 1'b1;
                iface_start_next = next_header_position;
              end else if (hdr_len == 8'd0) begin
                walk_stopped_next = 1'b1;
              end else if (hdr_len == 8'd1) begin
                next_header_position_next = byte_position;
                hdr_len_next = data_byte;
              end else begin
                next_header_position_next = hdr_sat;
              end
            end
          end
          if (at_sub) begin
            iface_subclass_next = data_byte;
          end
          if (at_proto) begin
            iface_protocol_next = data_byte;
          end
          byte_position_next = byte_position + PosW'(1);
        end
      end
      ACT_DONE: begin
        if (slot_busy) begin
          slot_busy_next = 1'b0;
          last_response_next = response;
        end
      end
      ACT_TICK: begin
        if (wait_count != 8'd0) begin
          wait_count_next = wait_count - 8'd1;
        end
      end
      ACT_STEP: begin
        if (!(slot_assigned && slot_busy)) begin
          if (sim_mode) begin
            wait_count_next = 8'd0;
          end
          if (wait_zero) begin
            unique case (phase)
              PH_GET: begin
                proto_next = detected;
                slot_number_next = (detected == ProtoMouse) ? SlotMouse : SlotOther;
                slot_assigned_next = 1'b1;
                if (detected == ProtoKbd) begin
                  kind_next = KIND_KBD;
                  phase_next = PH_KBD1;
                end else if (detected == ProtoMouse) begin
                  kind_next = KIND_MOUSE;
                  phase_next = PH_MSE1;
                end else begin
                  kind_next = KIND_UNREC;
                end
              end
              PH_MSE1, PH_KBD1: begin
                kind_next = KIND_ISSUE;
                len_next = is_mouse ? LenMouse : LenKbd;
                proto_next = is_mouse ? ProtoMouse : ProtoKbd;
                slot_busy_next = 1'b1;
                phase_next = is_mouse ? PH_MSE2 : PH_KBD2;
              end
              PH_MSE2, PH_KBD2: begin
                proto_next = is_mouse ? ProtoMouse : ProtoKbd;
                if (last_response == RESP_STALL) begin
                  kind_next = KIND_STALL;
                  phase_next = PH_IDLE;
                end else begin
                  kind_next = (last_response == RESP_ERROR) ? KIND_RPT_ER : KIND_RPT_OK;
                  phase_next = is_mouse ? PH_MSE1 : PH_KBD1;
                  wait_count_next = poll_interval;
                end
              end
              PH_IDLE: begin
                wait_count_next = idle_interval;
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sim_mode      <= 1'b0;
      poll_interval <= PollReset;
      idle_interval <= IdleReset;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SIM:  sim_mode      <= cfg_data[0];
        REG_POLL: poll_interval <= cfg_data;
        REG_IDLE: idle_interval <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_GET;
      slot_assigned        <= 1'b0;
      slot_busy            <= 1'b0;
      slot_number          <= 3'd0;
      last_response        <= 2'd0;
      wait_count           <= 8'd0;
      byte_position        <= '0;
      next_header_position <= '0;
      total_length         <= PosMax;
      iface_found          <= 1'b0;
      iface_start          <= '0;
      iface_subclass       <= 8'd0;
      iface_protocol       <= 8'd0;
      hdr_len              <= 8'd0;
      walk_stopped         <= 1'b0;
    end else if (in_fire) begin
      phase                <= phase_next;
      slot_assigned        <= slot_assigned_next;
      slot_busy            <= slot_busy_next;
      slot_number          <= slot_number_next;
      last_response        <= last_response_next;
      wait_count           <= wait_count_next;
      byte_position        <= byte_position_next;
      next_header_position <= next_header_position_next;
      total_length         <= total_length_next;
      iface_found          <= iface_found_next;
      iface_start          <= iface_start_next;
      iface_subclass       <= iface_subclass_next;
      iface_protocol       <= iface_protocol_next;
      hdr_len              <= hdr_len_next;
      walk_stopped         <= walk_stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind           <= kind_next;
      protocol       <= proto_next;
      endpoint_slot  <= slot_number_next;
      request_length <= len_next;
    end
  end

  `HBDP_ASSERT_IMP(a_busy_assigned, slot_busy, slot_assigned)
  `HBDP_ASSERT_IMP(a_len_on_issue, out_valid && (kind == KIND_ISSUE),
                   (request_length == LenMouse) || (request_length == LenKbd))
  `HBDP_ASSERT_NXT(a_fire_valid, in_fire, out_valid)
  `HBDP_ASSERT_NXT(a_tick_count, in_fire && (action == ACT_TICK) && (wait_count != 8'd0),
                   wait_count == ($past(wait_count) - 8'd1))

endmodule

[tb/sv/hid_boot_device_poller_top_tb.sv]
// ---------------------------------------------------------------------------
// hid_boot_device_poller_top_tb
// Streams a configuration descriptor into the boot device poller, then runs
// the poll loop (issue, completion, report, tick countdown) under several
// register settings. Every request is predicted in the bench and each result
// is checked in order against the prediction. Both handshakes see random
// gaps. Each run picks one descriptor shape at random.
// ---------------------------------------------------------------------------
module hid_boot_device_poller_top_tb
  import hbdp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] DescConfig   = 8'h02;
  localparam logic [7:0] DescHid      = 8'h21;
  localparam logic [7:0] DescEndpoint = 8'h05;
  localparam logic [7:0] ClassHid     = 8'h03;

  typedef enum {
    DESC_KBD,
    DESC_MOUSE,
    DESC_NOT_BOOT,
    DESC_ZERO_LEN,
    DESC_AT_TOTAL,
    DESC_LONG_WALK
  } desc_kind_t;

  typedef struct packed {
    action_t    act;
    logic [7:0] data;
    resp_t      resp;
  } host_req_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] protocol;
    logic [2:0] slot;
    logic [3:0] req_len;
  } host_event_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] action = ACT_TICK;
  logic [7:0] data_byte = '0;
  logic [1:0] response = RESP_OK;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] kind;
  logic [7:0] protocol;
  logic [2:0] endpoint_slot;
  logic [3:0] request_length;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_NONE;
  logic [7:0] cfg_data = '0;

  hid_boot_device_poller_top DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .data_byte      (data_byte),
    .response       (response),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .protocol       (protocol),
    .endpoint_slot  (endpoint_slot),
    .request_length (request_length),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  host_req_t   host_reqs[$];
  host_event_t pending_events[$];
  host_req_t   cur_req;
  int unsigned reqs_planned = 0;
  int unsigned mismatch_count = 0;
  logic        req_taken = 1'b0;
  logic        resp_taken = 1'b0;
  logic        req_in_flight = 1'b0;
  int unsigned req_gap = 0;
  int unsigned ready_hold = 0;
  logic        in_calm = 1'b0;
  logic        out_calm = 1'b0;
  logic        flood = 1'b0;

  // sequencer image
  logic        cfg_sim = 1'b0;
  logic [7:0]  cfg_poll = PollReset;
  logic [7:0]  cfg_idle = IdleReset;
  phase_t      seq_phase = PH_GET;
  logic        slot_taken = 1'b0;
  logic        slot_busy = 1'b0;
  logic [2:0]  slot_num = '0;
  resp_t       last_resp = RESP_OK;
  logic [7:0]  wait_left = '0;
  logic [15:0] walk_pos = '0;
  logic [15:0] hdr_pos = '0;
  logic [15:0] total_len = 16'hFFFF;
  logic [7:0]  hdr_len = '0;
  logic        walk_stopped = 1'b0;
  logic        iface_seen = 1'b0;
  logic [15:0] iface_pos = '0;
  logic [7:0]  iface_sub = '0;
  logic [7:0]  iface_proto = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic host_event_t advance_host_sequencer(host_req_t r);
    host_event_t ev;
    logic [16:0] hdr_end;
    logic [7:0]  found;
    logic        is_mouse;
    ev.kind = KIND_NONE;
    ev.protocol = '0;
    ev.req_len = '0;
    case (r.act)
      ACT_BYTE: begin
        if (walk_pos != PosMax) begin
          if (walk_pos == 16'd2) total_len[7:0] = r.data;
          if (walk_pos == 16'd3) total_len[15:8] = r.data;
          if (!walk_stopped && !iface_seen && hdr_pos < total_len) begin
            if (walk_pos == hdr_pos) begin
              hdr_len = r.data;
            end else if ({1'b0, walk_pos} == {1'b0, hdr_pos} + 17'd1) begin
              if (r.data == DescIface) begin
                iface_seen = 1'b1;
                iface_pos = hdr_pos;
              end else if (hdr_len == 8'd0) begin
                walk_stopped = 1'b1;
              end else if (hdr_len == 8'd1) begin
                hdr_pos = walk_pos;
                hdr_len = r.data;
              end else begin
                hdr_end = {1'b0, hdr_pos} + {9'd0, hdr_len};
                hdr_pos = hdr_end[16] ? PosMax : hdr_end[15:0];
              end
            end
          end
          if (iface_seen) begin
            if ({1'b0, walk_pos} == {1'b0, iface_pos} + {13'd0, OffSubclass})
              iface_sub = r.data;
            if ({1'b0, walk_pos} == {1'b0, iface_pos} + {13'd0, OffProtocol})
              iface_proto = r.data;
          end
          walk_pos = walk_pos + 16'd1;
        end
      end
      ACT_DONE: begin
        if (slot_busy) begin
          slot_busy = 1'b0;
          last_resp = r.resp;
        end
      end
      ACT_TICK: begin
        if (wait_left != 8'd0) wait_left = wait_left - 8'd1;
      end
      default: begin
        if (!(slot_taken && slot_busy)) begin
          if (cfg_sim) wait_left = '0;
          if (wait_left == 8'd0) begin
            is_mouse = (seq_phase == PH_MSE1 || seq_phase == PH_MSE2);
            case (seq_phase)
              PH_GET: begin
                if (!iface_seen || iface_pos >= total_len || iface_sub != SubclassBoot)
                  found = '0;
                else
                  found = iface_proto;
                ev.protocol = found;
                slot_num = (found == ProtoMouse) ? SlotMouse : SlotOther;
                slot_taken = 1'b1;
                if (found == ProtoKbd) begin
                  ev.kind = KIND_KBD;
                  seq_phase = PH_KBD1;
                end else if (found == ProtoMouse) begin
                  ev.kind = KIND_MOUSE;
                  seq_phase = PH_MSE1;
                end else begin
                  ev.kind = KIND_UNREC;
                end
              end
              PH_MSE1, PH_KBD1: begin
                ev.kind = KIND_ISSUE;
                ev.req_len = is_mouse ? LenMouse : LenKbd;
                ev.protocol = is_mouse ? ProtoMouse : ProtoKbd;
                slot_busy = 1'b1;
                if (is_mouse) seq_phase = PH_MSE2;
                else seq_phase = PH_KBD2;
              end
              PH_MSE2, PH_KBD2: begin
                ev.protocol = is_mouse ? ProtoMouse : ProtoKbd;
                if (last_resp == RESP_STALL) begin
                  ev.kind = KIND_STALL;
                  seq_phase = PH_IDLE;
                end else begin
                  if (last_resp == RESP_ERROR) ev.kind = KIND_RPT_ER;
                  else ev.kind = KIND_RPT_OK;
                  if (is_mouse) seq_phase = PH_MSE1;
                  else seq_phase = PH_KBD1;
                  wait_left = cfg_poll;
                end
              end
              PH_IDLE: begin
                wait_left = cfg_idle;
              end
              default: ;
            endcase
          end
        end
      end
    endcase
    ev.slot = slot_num;
    return ev;
  endfunction

  function automatic int unsigned pick_gap(logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || flood) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [7:0] other_type();
    logic [7:0] t;
    t = 8'($urandom_range(0, 255));
    if (t == DescIface) t = DescHid;
    return t;
  endfunction

  function automatic resp_t pick_resp();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return RESP_OK;
    if (r < 17) return RESP_ERROR;
    return RESP_OTHER;
  endfunction

  task automatic push_byte(logic [7:0] b);
    host_req_t q;
    q.act = ACT_BYTE;
    q.data = b;
    q.resp = resp_t'($urandom_range(0, 3));
    host_reqs.push_back(q);
    reqs_planned++;
  endtask

  task automatic push_ctl(action_t a, resp_t r);
    host_req_t q;
    q.act = a;
    q.data = 8'($urandom_range(0, 255));
    q.resp = r;
    host_reqs.push_back(q);
    reqs_planned++;
  endtask

  task automatic wait_drained();
    while (host_reqs.size() != 0 || req_in_flight || pending_events.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_config(logic sim, logic [7:0] poll, logic [7:0] idle);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_SIM;
    cfg_data <= {7'd0, sim};
    @(negedge clk);
    cfg_index <= REG_POLL;
    cfg_data <= poll;
    @(negedge clk);
    cfg_index <= REG_IDLE;
    cfg_data <= idle;
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_index <= REG_NONE;
    cfg_sim = sim;
    cfg_poll = poll;
    cfg_idle = idle;
  endtask

  task automatic build_descriptor(desc_kind_t dk);
    logic [7:0]  desc[$];
    logic [7:0]  b;
    logic [7:0]  sub;
    logic [7:0]  proto;
    int unsigned p;
    int unsigned hdr;
    int unsigned len;
    int unsigned total;
    if (dk == DESC_LONG_WALK) begin
      flood = 1'b1;
      hdr = 9;
      for (p = 0; p < 32'h1_0010; p++) begin
        b = 8'($urandom_range(0, 255));
        if (p == 0) b = 8'd9;
        else if (p == 1) b = DescConfig;
        else if (p == 2 || p == 3) b = 8'hFF;
        else if (p == hdr) b = 8'hFF;
        else if (p == hdr + 1) begin
          b = other_type();
          hdr = hdr + 255;
        end
        push_byte(b);
      end
    end else if (dk == DESC_AT_TOTAL) begin
      desc = '{8'd9, DescIface, 8'd0, 8'd0};
      repeat (2) desc.push_back(8'($urandom_range(0, 255)));
      desc.push_back(SubclassBoot);
      desc.push_back($urandom_range(0, 1) ? ProtoKbd : ProtoMouse);
      desc.push_back(8'($urandom_range(0, 255)));
    end else begin
      desc = '{8'd9, DescConfig, 8'd0, 8'd0};
      repeat (5) desc.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2)) begin
        len = $urandom_range(2, 12);
        desc.push_back(8'(len));
        desc.push_back(other_type());
        repeat (len - 2) desc.push_back(8'($urandom_range(0, 255)));
      end
      if (dk == DESC_ZERO_LEN) begin
        desc.push_back(8'd0);
        desc.push_back(other_type());
      end
      // length-one header: its type byte is the next header's length
      if ($urandom_range(0, 1)) desc.push_back(8'd1);
      sub = SubclassBoot;
      proto = (dk == DESC_MOUSE) ? ProtoMouse : ProtoKbd;
      if (dk == DESC_NOT_BOOT) begin
        if ($urandom_range(0, 1)) sub = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(2, 255));
        else proto = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(3, 255));
      end
      desc.push_back(8'd9);
      desc.push_back(DescIface);
      repeat (3) desc.push_back(8'($urandom_range(0, 255)));
      desc.push_back(ClassHid);
      desc.push_back(sub);
      desc.push_back(proto);
      desc.push_back(8'($urandom_range(0, 255)));
      desc.push_back(8'd9);
      desc.push_back(DescHid);
      repeat (7) desc.push_back(8'($urandom_range(0, 255)));
      desc.push_back(8'd7);
      desc.push_back(DescEndpoint);
      repeat (5) desc.push_back(8'($urandom_range(0, 255)));
      total = desc.size();
      desc[2] = total[7:0];
      desc[3] = total[15:8];
    end
    foreach (desc[i]) begin
      push_byte(desc[i]);
      if ($urandom_range(0, 15) == 0) push_ctl(ACT_STEP, resp_t'($urandom_range(0, 3)));
    end
  endtask

  task automatic poll_traffic(int unsigned n);
    int unsigned stop_at;
    int unsigned ticks;
    int unsigned early;
    stop_at = reqs_planned + n;
    while (reqs_planned < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        push_ctl(ACT_STEP, resp_t'($urandom_range(0, 3)));
        if ($urandom_range(0, 3) == 0) push_ctl(ACT_STEP, resp_t'($urandom_range(0, 3)));
        push_ctl(ACT_DONE, pick_resp());
        push_ctl(ACT_STEP, resp_t'($urandom_range(0, 3)));
        ticks = cfg_sim ? $urandom_range(0, 2) : cfg_poll;
        if (!cfg_sim && ticks != 0 && $urandom_range(0, 2) == 0) begin
          early = $urandom_range(0, ticks - 1);
          repeat (early) push_ctl(ACT_TICK, resp_t'($urandom_range(0, 3)));
          push_ctl(ACT_STEP, resp_t'($urandom_range(0, 3)));
          ticks = ticks - early;
        end
        repeat (ticks) push_ctl(ACT_TICK, resp_t'($urandom_range(0, 3)));
      end else if ($urandom_range(0, 3) == 0) begin
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        push_ctl(action_t'($urandom_range(1, 3)), pick_resp());
      end
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (req_taken) req_in_flight = 1'b0;
      if (!req_in_flight) begin
        if (req_gap != 0) begin
          req_gap--;
          in_valid <= 1'b0;
        end else if (host_reqs.size() != 0) begin
          cur_req = host_reqs.pop_front();
          action <= cur_req.act;
          data_byte <= cur_req.data;
          response <= cur_req.resp;
          in_valid <= 1'b1;
          req_in_flight = 1'b1;
          if ($urandom_range(0, 47) == 0) in_calm = !in_calm;
          req_gap = pick_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (resp_taken && ready_hold == 0) begin
        if ($urandom_range(0, 47) == 0) out_calm = !out_calm;
        ready_hold = pick_gap(out_calm);
      end
      if (ready_hold != 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    host_event_t want;
    req_taken = 1'b0;
    resp_taken = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        req_taken = 1'b1;
        pending_events.push_back(advance_host_sequencer(cur_req));
      end
      if (out_valid && out_ready) begin
        resp_taken = 1'b1;
        if (pending_events.size() == 0) begin
          if (mismatch_count < 100)
            $display("%0t: result with none expected: kind %0d protocol %0d slot %0d length %0d",
                     $time, kind, protocol, endpoint_slot, request_length);
          mismatch_count++;
        end else begin
          want = pending_events.pop_front();
          if ({kind, protocol, endpoint_slot, request_length} !== want) begin
            if (mismatch_count < 100)
              $display("%0t: expected kind %0d protocol %0d slot %0d length %0d, got %0d %0d %0d %0d",
                       $time, want.kind, want.protocol, want.slot, want.req_len,
                       kind, protocol, endpoint_slot, request_length);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    desc_kind_t  dk;
    int unsigned r;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_ctl(ACT_STEP, RESP_OK);
    push_ctl(ACT_TICK, RESP_OK);
    push_ctl(ACT_DONE, RESP_STALL);
    push_ctl(ACT_DONE, RESP_OTHER);

    r = $urandom_range(0, 11);
    if (r < 5) dk = DESC_KBD;
    else if (r < 10) dk = DESC_MOUSE;
    else begin
      r = $urandom_range(0, 3);
      if (r == 0) dk = DESC_NOT_BOOT;
      else if (r == 1) dk = DESC_ZERO_LEN;
      else if (r == 2) dk = DESC_AT_TOTAL;
      else dk = DESC_LONG_WALK;
    end
    build_descriptor(dk);
    wait_drained();
    flood = 1'b0;

    push_byte(8'h00);
    push_byte(8'hFF);
    push_ctl(ACT_STEP, RESP_OK);
    push_ctl(ACT_STEP, RESP_OK);
    push_ctl(ACT_STEP, RESP_OK);
    push_ctl(ACT_DONE, RESP_OTHER);
    push_ctl(ACT_STEP, RESP_OK);
    push_ctl(ACT_STEP, RESP_OK);
    repeat (cfg_poll) push_ctl(ACT_TICK, RESP_OK);
    push_ctl(ACT_STEP, RESP_OK);
    push_ctl(ACT_DONE, RESP_ERROR);
    push_ctl(ACT_STEP, RESP_OK);
    poll_traffic(150);

    wait_drained();
    set_config(1'b1, 8'd255, 8'd0);
    poll_traffic(120);

    wait_drained();
    set_config(1'b0, 8'd0, 8'd255);
    poll_traffic(120);

    wait_drained();
    set_config(1'b0, 8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)));
    poll_traffic(150);
    push_ctl(ACT_STEP, RESP_OK);
    push_ctl(ACT_DONE, RESP_STALL);
    push_ctl(ACT_STEP, RESP_OK);
    push_ctl(ACT_STEP, RESP_OK);
    push_ctl(ACT_STEP, RESP_OK);
    repeat (cfg_idle) push_ctl(ACT_TICK, RESP_OK);
    push_ctl(ACT_STEP, RESP_OK);
    push_ctl(ACT_DONE, RESP_OK);

    wait_drained();
    if (mismatch_count == 0 && pending_events.size() == 0)
      $display("hid_boot_device_poller_top_tb OK");
    else
      $display("hid_boot_device_poller_top_tb NOT OK");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("hid_boot_device_poller_top_tb NOT OK");
    $finish;
  end

endmodule
